### rtl/utf8_utf16_transcoder_assert.svh
// ----------------------------------------------------------------------------
// UTF-8 / UTF-16 transcoder assertion macros
// Concurrent assertion wrappers sampled on the rising clock edge and
// disabled while the asynchronous reset is asserted.
// ----------------------------------------------------------------------------
`ifndef UTF8_UTF16_TRANSCODER_ASSERT_SVH
`define UTF8_UTF16_TRANSCODER_ASSERT_SVH

`ifndef ASSERT_OFF

// Condition that must hold at every clock edge out of reset.
`define UTC_ASSERT(lbl, clk_s, rst_n_s, expr) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (expr)) \
		else $error("transcoder assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define UTC_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error("transcoder assertion failed");

`else

`define UTC_ASSERT(lbl, clk_s, rst_n_s, expr)
`define UTC_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons)

`endif

`endif

### rtl/utf_tc_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 / UTF-16 transcoder package
// Result and stream state types, result kinds, register indexes and the
// UTF-8 byte encoder shared by the transcoder logic.
// ----------------------------------------------------------------------------
`default_nettype none

package utf_tc_pkg;

	// Result kinds.
	localparam logic [1:0] KIND_DATA    = 2'd0;
	localparam logic [1:0] KIND_DONE    = 2'd1;
	localparam logic [1:0] KIND_INVALID = 2'd2;
	localparam logic [1:0] KIND_ASCII   = 2'd3;

	// Configuration register indexes.
	localparam logic REG_DIRECTION = 1'b0;
	localparam logic REG_BOM       = 1'b1;

	// Direction codes.
	localparam logic DIR_ENCODE = 1'b0;

	// Maximum number of results one input word can produce.
	localparam int MAX_RESULTS = 4;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
	localparam int IDX_W       = $clog2(MAX_RESULTS);

	// Code point constants.
	localparam logic [20:0] CP_SUPP_BASE = 21'h10000;
	localparam logic [15:0] HI_SURR_MIN  = 16'hd800;
	localparam logic [15:0] HI_SURR_MAX  = 16'hdbff;
	localparam logic [15:0] LO_SURR_BASE = 16'hdc00;
	localparam logic [15:0] BOM_UNIT     = 16'hfeff;

	typedef struct packed {
		logic [15:0] out_unit;
		logic [1:0]  kind;
		logic        last;
	} result_t;

	typedef struct packed {
		logic        started;
		logic [1:0]  bytes_pending;
		logic [20:0] code_accum;
		logic [9:0]  high_half;
		logic        high_waiting;
		logic        saw_multibyte;
		logic        first_sequence;
		logic        error_latched;
	} stream_t;

	localparam stream_t STREAM_CLEAR = '{
		started:        1'b0,
		bytes_pending:  2'd0,
		code_accum:     21'd0,
		high_half:      10'd0,
		high_waiting:   1'b0,
		saw_multibyte:  1'b0,
		first_sequence: 1'b1,
		error_latched:  1'b0
	};

	typedef struct packed {
		logic [CNT_W-1:0]  count;
		logic [3:0][7:0]   bytes;
	} enc_t;

	// Split one code point into its UTF-8 byte sequence.
	function automatic enc_t utf8_encode(input logic [20:0] cp);
		enc_t e;
		e = '0;
		if (cp >= 21'h10000) begin
			e.count    = CNT_W'(4);
			e.bytes[0] = 8'hf0 | {5'b0, cp[20:18]};
			e.bytes[1] = 8'h80 | {2'b0, cp[17:12]};
			e.bytes[2] = 8'h80 | {2'b0, cp[11:6]};
			e.bytes[3] = 8'h80 | {2'b0, cp[5:0]};
		end else if (cp >= 21'h00800) begin
			e.count    = CNT_W'(3);
			e.bytes[0] = 8'he0 | {4'b0, cp[15:12]};
			e.bytes[1] = 8'h80 | {2'b0, cp[11:6]};
			e.bytes[2] = 8'h80 | {2'b0, cp[5:0]};
		end else if (cp >= 21'h00080) begin
			e.count    = CNT_W'(2);
			e.bytes[0] = 8'hc0 | {3'b0, cp[10:6]};
			e.bytes[1] = 8'h80 | {2'b0, cp[5:0]};
		end else begin
			e.count    = CNT_W'(1);
			e.bytes[0] = cp[7:0];
		end
		return e;
	endfunction

endpackage

`default_nettype wire

### rtl/utf8_utf16_transcoder.sv
// ----------------------------------------------------------------------------
// UTF-8 / UTF-16 streaming transcoder
// Words pass through the input register and then the result register.
// Throughput: one word per cycle while each word yields at most one result
// and the output does not stall; a word with more results holds the result
// register; it drains one entry per unstalled cycle and refills as it empties.
// Reset clears the stream state and selects decode with BOM handling enabled.
// ----------------------------------------------------------------------------
`default_nettype none

`include "utf8_utf16_transcoder_assert.svh"

module utf8_utf16_transcoder
	import utf_tc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input channel.
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [15:0] code_unit,
	// Output channel.
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      out_unit,
	output logic [1:0]       kind,
	output logic             last,
	// Configuration write port.
	input  wire logic        wr_en,
	input  wire logic        wr_index,
	input  wire logic        wr_data
);

	logic             direction_q;
	logic             bom_enable_q;
	stream_t          st_q;
	stream_t          st_nxt;

	logic             valid_s1;
	logic [15:0]      unit_s1;

	result_t          obuf_q [MAX_RESULTS];
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] rd_q;

	result_t          res [MAX_RESULTS];
	logic [CNT_W-1:0] res_n;

	logic             in_take;
	logic             out_take;
	logic             buf_free;
	logic             proc;

	enc_t             enc;
	logic [20:0]      enc_cp;
	logic             enc_go;
	logic [20:0]      accum_new;
	logic [9:0]       half_new;
	logic [1:0]       pend_new;
	logic [20:0]      supp_off;
	logic [7:0]       byte_in;

	// Handshake and flow control.
	assign in_take  = in_valid && !in_stall;
	assign out_take = out_valid && !out_stall;
	assign buf_free = (cnt_q == '0) || ((cnt_q == CNT_W'(1)) && !out_stall);
	assign proc     = valid_s1 && buf_free;
	assign in_stall = valid_s1 && !buf_free;

	assign byte_in   = unit_s1[7:0];
	assign accum_new = {st_q.code_accum[14:0], byte_in[5:0]};
	assign half_new  = st_q.high_half | ((byte_in[7:6] != 2'b10) ? 10'd4 : 10'd0);
	assign pend_new  = st_q.bytes_pending - 2'd1;
	assign supp_off  = accum_new - CP_SUPP_BASE;
	assign enc       = utf8_encode(enc_cp);

	// Next stream state and the results of the word in the input register.
	always_comb begin
		st_nxt = st_q;
		res_n  = '0;
		enc_cp = '0;
		enc_go = 1'b0;
		for (int i = 0; i < MAX_RESULTS; i++) begin
			res[i] = '{out_unit: 16'd0, kind: KIND_DATA, last: 1'b0};
		end

		if (direction_q == DIR_ENCODE) begin
			if (!st_q.started) begin
				// Stream start: the UTF-8 BOM replaces the first word.
				st_nxt.started  = 1'b1;
				res[0].out_unit = 16'h00ef;
				res[1].out_unit = 16'h00bb;
				res[2].out_unit = 16'h00bf;
				res_n           = CNT_W'(3);
				if (unit_s1 == 16'd0) begin
					res[3] = '{out_unit: 16'd0, kind: KIND_DONE, last: 1'b1};
					res_n  = CNT_W'(4);
					st_nxt = STREAM_CLEAR;
				end
			end else if (unit_s1 == 16'd0) begin
				res[0] = '{out_unit: 16'd0, kind: KIND_DONE, last: 1'b1};
				res_n  = CNT_W'(1);
				st_nxt = STREAM_CLEAR;
			end else if (st_q.high_waiting) begin
				// Join the held high half with this word as the low half.
				enc_cp              = CP_SUPP_BASE + {1'b0, st_q.high_half, unit_s1[9:0]};
				enc_go              = 1'b1;
				st_nxt.high_waiting = 1'b0;
				st_nxt.high_half    = '0;
			end else if ((unit_s1 >= HI_SURR_MIN) && (unit_s1 <= HI_SURR_MAX)) begin
				st_nxt.high_half    = unit_s1[9:0];
				st_nxt.high_waiting = 1'b1;
			end else begin
				enc_cp = {5'b0, unit_s1};
				enc_go = 1'b1;
			end
			if (enc_go) begin
				for (int i = 0; i < MAX_RESULTS; i++) begin
					res[i].out_unit = {8'h00, enc.bytes[i]};
				end
				res_n = enc.count;
			end
		end else begin
			// Decode: the UTF-16 BOM opens the stream when enabled.
			if (!st_q.started) begin
				st_nxt.started = 1'b1;
				if (bom_enable_q) begin
					res[0].out_unit = BOM_UNIT;
					res_n           = CNT_W'(1);
				end
			end

			if (st_q.error_latched) begin
				if (byte_in == 8'd0) begin
					res[res_n[IDX_W-1:0]] = '{out_unit: 16'd0, kind: KIND_INVALID, last: 1'b1};
					res_n  = res_n + CNT_W'(1);
					st_nxt = STREAM_CLEAR;
				end
			end else if (st_q.bytes_pending != 2'd0) begin
				if (byte_in == 8'd0) begin
					res[res_n[IDX_W-1:0]] = '{out_unit: 16'd0, kind: KIND_INVALID, last: 1'b1};
					res_n  = res_n + CNT_W'(1);
					st_nxt = STREAM_CLEAR;
				end else if (pend_new != 2'd0) begin
					st_nxt.code_accum    = accum_new;
					st_nxt.high_half     = half_new;
					st_nxt.bytes_pending = pend_new;
				end else begin
					// Sequence complete: drop a leading BOM, else emit one or two units.
					st_nxt.bytes_pending  = 2'd0;
					st_nxt.first_sequence = 1'b0;
					st_nxt.high_half      = '0;
					st_nxt.code_accum     = '0;
					if ((half_new[1:0] == 2'd3) && st_q.first_sequence && bom_enable_q
						&& (accum_new == {5'b0, BOM_UNIT}) && !half_new[2]) begin
						res_n = res_n;
					end else if (half_new[1:0] == 2'd0) begin
						res[res_n[IDX_W-1:0]].out_unit = HI_SURR_MIN + {6'b0, supp_off[19:10]};
						res[IDX_W'(res_n + CNT_W'(1))].out_unit =
							LO_SURR_BASE + {6'b0, supp_off[9:0]};
						res_n = res_n + CNT_W'(2);
					end else begin
						res[res_n[IDX_W-1:0]].out_unit = accum_new[15:0];
						res_n = res_n + CNT_W'(1);
					end
				end
			end else if (byte_in == 8'd0) begin
				res[res_n[IDX_W-1:0]] = '{out_unit: 16'd0,
					kind: (bom_enable_q && !st_q.saw_multibyte) ? KIND_ASCII : KIND_DONE,
					last: 1'b1};
				res_n  = res_n + CNT_W'(1);
				st_nxt = STREAM_CLEAR;
			end else begin
				// Lead byte classification.
				priority if (byte_in >= 8'hfe) begin
					st_nxt.error_latched = 1'b1;
				end else if (byte_in >= 8'hf0) begin
					st_nxt.code_accum    = {18'b0, byte_in[2:0]};
					st_nxt.bytes_pending = 2'd3;
					st_nxt.high_half     = 10'd0;
					st_nxt.saw_multibyte = 1'b1;
				end else if (byte_in >= 8'he0) begin
					st_nxt.code_accum    = {17'b0, byte_in[3:0]};
					st_nxt.bytes_pending = 2'd2;
					st_nxt.high_half     = 10'd3;
					st_nxt.saw_multibyte = 1'b1;
				end else if (byte_in >= 8'hc0) begin
					st_nxt.code_accum    = {16'b0, byte_in[4:0]};
					st_nxt.bytes_pending = 2'd1;
					st_nxt.high_half     = 10'd2;
					st_nxt.saw_multibyte = 1'b1;
				end else if (byte_in >= 8'h80) begin
					st_nxt.error_latched = 1'b1;
				end else begin
					res[res_n[IDX_W-1:0]].out_unit = {8'h00, byte_in};
					res_n                 = res_n + CNT_W'(1);
					st_nxt.first_sequence = 1'b0;
				end
			end
		end
	end

	// Configuration registers and stream state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q  <= 1'b1;
			bom_enable_q <= 1'b1;
			st_q         <= STREAM_CLEAR;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_DIRECTION: direction_q  <= wr_data;
				REG_BOM:       bom_enable_q <= wr_data;
				default:       direction_q  <= direction_q;
			endcase
			st_q <= STREAM_CLEAR;
		end else if (proc) begin
			st_q <= st_nxt;
		end
	end

	// Input register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_take) begin
			unit_s1 <= code_unit;
		end
	end

	// Result register control: load a full word's results, drain one per unstalled cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q  <= '0;
		end else if (proc) begin
			cnt_q <= res_n;
			rd_q  <= '0;
		end else if (out_take) begin
			cnt_q <= cnt_q - CNT_W'(1);
			rd_q  <= rd_q + IDX_W'(1);
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (proc) begin
			for (int i = 0; i < MAX_RESULTS; i++) begin
				obuf_q[i] <= res[i];
			end
		end
	end

	assign out_valid = (cnt_q != '0);
	assign out_unit  = obuf_q[rd_q].out_unit;
	assign kind      = obuf_q[rd_q].kind;
	assign last      = obuf_q[rd_q].last;

	// Assertions.
	`UTC_ASSERT(a_cnt_range, clk, arst_n, cnt_q <= CNT_W'(MAX_RESULTS))
	`UTC_ASSERT(a_load_drained, clk, arst_n, !proc || (cnt_q == '0) || ((cnt_q == CNT_W'(1)) && out_take))
	`UTC_ASSERT(a_last_final, clk, arst_n, !(out_valid && last) || (cnt_q == CNT_W'(1)))
	`UTC_ASSERT(a_empty_ready, clk, arst_n, valid_s1 || !in_stall)
	`UTC_ASSERT_NEXT(a_cfg_clears, clk, arst_n, wr_en, !st_q.started && st_q.first_sequence)

endmodule

`default_nettype wire
